[design/swps_pkg.sv]
package swps_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 7;
    localparam int SUM_W       = 14;
    localparam int POS_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int ACT_W       = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_BYTE = 2'd0,
        ACT_ACK  = 2'd1,
        ACT_NACK = 2'd2
    } action_t;

    typedef struct packed {
        logic                    refused;
        logic                    kind;
        logic [LEN_W-1:0]        length;
        logic signed [SUM_W-1:0] sum;
    } cmd_t;

    typedef struct packed {
        logic we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } ram_wr_t;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_SHOW = 1'b1
    } back_state_t;

endpackage

[design/stop_and_wait_packet_sender_unit.sv]
// Stop-and-wait packet sender. Message bytes, ACK and NACK replies enter one a cycle on the
// input channel; any work each causes is queued for the emitter. Bytes gather in a 16-entry
// packet buffer with a running signed 14-bit checksum; a full buffer (per cfg_data, clamped
// to 1..16) or a byte marked last sends the packet out one payload byte per cycle while
// out_ready is high, starting the cycle after its request reaches the emitter, paced by the
// single buffer read port. A NACK resends the held packet, an ACK frees it. Wrong-time
// bytes or replies, and unknown actions, give one result with refused set. While a packet
// request is outstanding, from acceptance of the item that causes it until its final byte
// is taken, the input channel holds off; refused results queue two deep.
module stop_and_wait_packet_sender_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swps_pkg::LEN_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swps_pkg::ACT_W-1:0]        action,
    input  logic [swps_pkg::BYTE_W-1:0]       data_byte,
    input  logic                              last_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              packet_kind,
    output logic [swps_pkg::LEN_W-1:0]        packet_length,
    output logic signed [swps_pkg::SUM_W-1:0] packet_sum,
    output logic [swps_pkg::BYTE_W-1:0]       payload_byte,
    output logic [swps_pkg::POS_W-1:0]        byte_position,
    output logic                              end_of_packet,
    output logic                              refused
);

    logic                          push;
    swps_pkg::cmd_t                push_cmd;
    logic                          q_full;
    logic                          q_valid;
    logic                          pop;
    swps_pkg::cmd_t                q_cmd;
    logic                          done;
    logic                          pending;
    swps_pkg::ram_wr_t             ram_wr;
    logic                          ram_re;
    logic [swps_pkg::ADDR_W-1:0]   ram_raddr;
    logic [swps_pkg::BYTE_W-1:0]   ram_rdata;

    swps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .done      (done),
        .pending   (pending),
        .ram_wr    (ram_wr)
    );

    swps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_cmd)
    );

    swps_ram #(
        .WIDTH (swps_pkg::BYTE_W),
        .DEPTH (swps_pkg::MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .pop           (pop),
        .q_cmd         (q_cmd),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packet_kind   (packet_kind),
        .packet_length (packet_length),
        .packet_sum    (packet_sum),
        .payload_byte  (payload_byte),
        .byte_position (byte_position),
        .end_of_packet (end_of_packet),
        .refused       (refused),
        .done          (done)
    );

    // buffer never written while a packet is being read out
    assert property (@(posedge clk) disable iff (!rst_n) ram_wr.we |-> !pending)
        else $error("packet buffer written while a packet is outstanding");

    // a packet only finishes if one was outstanding
    assert property (@(posedge clk) disable iff (!rst_n) done |-> pending)
        else $error("packet finished with none outstanding");

    // no request lost to a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
        else $error("request pushed into full queue");

    // byte index stays inside the packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !refused) |-> (swps_pkg::LEN_W'(byte_position) < packet_length))
        else $error("byte position beyond packet length");

endmodule

[design/swps_ram.sv]
module swps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/swps_queue.sv]
module swps_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swps_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output swps_pkg::cmd_t    head
);

    swps_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/swps_front.sv]
module swps_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swps_pkg::LEN_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swps_pkg::ACT_W-1:0]    action,
    input  logic [swps_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    input  logic                          q_full,
    output logic                          push,
    output swps_pkg::cmd_t                push_cmd,
    input  logic                          done,
    output logic                          pending,
    output swps_pkg::ram_wr_t             ram_wr
);

    logic [swps_pkg::LEN_W-1:0]        size_reg, size_next;
    logic [swps_pkg::LEN_W-1:0]        fill_reg, fill_next;
    logic signed [swps_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                              waiting_reg, waiting_next;
    logic                              held_last_reg, held_last_next;
    logic                              pending_reg, pending_next;

    logic                              accept;
    logic [swps_pkg::LEN_W-1:0]        eff_size;
    logic [swps_pkg::LEN_W-1:0]        fill_inc;
    logic signed [swps_pkg::SUM_W-1:0] sum_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full && !pending_reg;
    assign accept    = in_valid && in_ready;
    assign pending   = pending_reg;

    assign fill_inc = fill_reg + swps_pkg::LEN_W'(1);
    assign sum_inc  = sum_reg + {{(swps_pkg::SUM_W - swps_pkg::BYTE_W)
                                  {data_byte[swps_pkg::BYTE_W-1]}}, data_byte};

    // size clamped to 1..MAX_PAYLOAD
    always_comb
    begin
        priority if (size_reg == '0)
        begin
            eff_size = swps_pkg::LEN_W'(1);
        end
        else if (size_reg > swps_pkg::LEN_W'(swps_pkg::MAX_PAYLOAD))
        begin
            eff_size = swps_pkg::LEN_W'(swps_pkg::MAX_PAYLOAD);
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    always_comb
    begin
        size_next      = size_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        waiting_next   = waiting_reg;
        held_last_next = held_last_reg;
        push           = 1'b0;
        push_cmd       = '0;
        ram_wr.we      = 1'b0;
        ram_wr.addr    = fill_reg[swps_pkg::ADDR_W-1:0];
        ram_wr.data    = data_byte;

        if (cfg_valid)
        begin
            size_next = cfg_data;
        end

        if (accept)
        begin
            unique case (action)
                swps_pkg::ACT_BYTE:
                begin
                    if (waiting_reg)
                    begin
                        push             = 1'b1;
                        push_cmd.refused = 1'b1;
                    end
                    else
                    begin
                        ram_wr.we = 1'b1;
                        fill_next = fill_inc;
                        sum_next  = sum_inc;
                        if (last_byte || fill_inc >= eff_size)
                        begin
                            held_last_next  = last_byte;
                            waiting_next    = 1'b1;
                            push            = 1'b1;
                            push_cmd.kind   = last_byte;
                            push_cmd.length = fill_inc;
                            push_cmd.sum    = sum_inc;
                        end
                    end
                end
                swps_pkg::ACT_ACK:
                begin
                    if (waiting_reg)
                    begin
                        waiting_next   = 1'b0;
                        held_last_next = 1'b0;
                        fill_next      = '0;
                        sum_next       = '0;
                    end
                    else
                    begin
                        push             = 1'b1;
                        push_cmd.refused = 1'b1;
                    end
                end
                swps_pkg::ACT_NACK:
                begin
                    push = 1'b1;
                    if (waiting_reg)
                    begin
                        push_cmd.kind   = held_last_reg;
                        push_cmd.length = fill_reg;
                        push_cmd.sum    = sum_reg;
                    end
                    else
                    begin
                        push_cmd.refused = 1'b1;
                    end
                end
                default:
                begin
                    push             = 1'b1;
                    push_cmd.refused = 1'b1;
                end
            endcase
        end
    end

    // a packet is outstanding from its request until its last byte leaves
    always_comb
    begin
        pending_next = pending_reg;
        if (done)
        begin
            pending_next = 1'b0;
        end
        if (push && !push_cmd.refused)
        begin
            pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= swps_pkg::LEN_W'(16);
            fill_reg      <= '0;
            sum_reg       <= '0;
            waiting_reg   <= 1'b0;
            held_last_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            waiting_reg   <= waiting_next;
            held_last_reg <= held_last_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

[design/swps_back.sv]
module swps_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              pop,
    input  swps_pkg::cmd_t                    q_cmd,
    output logic                              ram_re,
    output logic [swps_pkg::ADDR_W-1:0]       ram_raddr,
    input  logic [swps_pkg::BYTE_W-1:0]       ram_rdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              packet_kind,
    output logic [swps_pkg::LEN_W-1:0]        packet_length,
    output logic signed [swps_pkg::SUM_W-1:0] packet_sum,
    output logic [swps_pkg::BYTE_W-1:0]       payload_byte,
    output logic [swps_pkg::POS_W-1:0]        byte_position,
    output logic                              end_of_packet,
    output logic                              refused,
    output logic                              done
);

    swps_pkg::back_state_t            state_reg, state_next;
    swps_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [swps_pkg::ADDR_W-1:0]      pos_reg, pos_next;
    logic                             last_beat;
    logic                             take;

    assign last_beat = (swps_pkg::LEN_W'(pos_reg) + swps_pkg::LEN_W'(1)) == cmd_reg.length;
    assign take      = (state_reg == swps_pkg::BACK_SHOW) && out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swps_pkg::BACK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = swps_pkg::BACK_SHOW;
                end
            end
            swps_pkg::BACK_SHOW:
            begin
                if (out_ready && (cmd_reg.refused || last_beat))
                begin
                    state_next = swps_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = swps_pkg::BACK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop       = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        cmd_next  = cmd_reg;
        pos_next  = pos_reg;
        done      = 1'b0;
        unique case (state_reg)
            swps_pkg::BACK_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    ram_re   = !q_cmd.refused;
                    cmd_next = q_cmd;
                    pos_next = '0;
                end
            end
            swps_pkg::BACK_SHOW:
            begin
                if (take && !cmd_reg.refused)
                begin
                    if (last_beat)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        pos_next  = pos_reg + swps_pkg::ADDR_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = pos_reg + swps_pkg::ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign out_valid     = (state_reg == swps_pkg::BACK_SHOW);
    assign refused       = cmd_reg.refused;
    assign packet_kind   = cmd_reg.refused ? 1'b0 : cmd_reg.kind;
    assign packet_length = cmd_reg.refused ? '0 : cmd_reg.length;
    assign packet_sum    = cmd_reg.refused ? '0 : cmd_reg.sum;
    assign payload_byte  = cmd_reg.refused ? '0 : ram_rdata;
    assign byte_position = cmd_reg.refused ? '0 : swps_pkg::POS_W'(pos_reg);
    assign end_of_packet = !cmd_reg.refused && last_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swps_pkg::BACK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
    end

endmodule
